FILE: src/assert_macros.svh
// Shared assertion macros, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/uemr_pkg.sv
package uemr_pkg;

  localparam int TICKS_W = 16;
  localparam int SCALE_W = 10;
  localparam int DIST_W  = 21;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd187;

  // count*scale, then /100 as ((p >> 2) * RECIP) >> RECIP_SHIFT, i.e. /4 then /25
  localparam int PROD_W      = TICKS_W + SCALE_W;
  localparam int QIN_W       = PROD_W - 2;
  localparam int RECIP_W     = 25;
  localparam int QPROD_W     = QIN_W + RECIP_W;
  localparam int RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP = 25'd21474837;
  localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;

  localparam logic [QUOT_W-1:0] NEAR_LIMIT = 20'd1000;
  localparam logic [QUOT_W-1:0] MID_LIMIT  = 20'd2000;
  localparam logic signed [DIST_W-1:0] NEAR_TRIM = 21'sd40;
  localparam logic signed [DIST_W-1:0] MID_TRIM  = 21'sd80;

  localparam int SAMPLES_DEF = 9;

  typedef struct packed {
    logic                     valid;
    logic signed [DIST_W-1:0] dist_hcm;
  } sample_push_t;

endpackage

FILE: src/uemr_front.sv
module uemr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [uemr_pkg::SCALE_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [uemr_pkg::TICKS_W-1:0]        echo_ticks,
  input  logic                                timed_out,
  output uemr_pkg::sample_push_t              push,
  input  logic                                push_ready
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} fstate_t;

  fstate_t                             state;
  logic [uemr_pkg::SCALE_W-1:0]        scale;
  logic [uemr_pkg::TICKS_W-1:0]        ticks;
  logic                                tmo;
  logic [uemr_pkg::PROD_W-1:0]         prod;
  logic [uemr_pkg::QPROD_W-1:0]        qprod;
  logic [uemr_pkg::QUOT_W-1:0]         quot;
  logic signed [uemr_pkg::DIST_W-1:0]  raw;
  logic signed [uemr_pkg::DIST_W-1:0]  dist_hcm;

  assign in_ready = (state == F_IDLE);

  always_comb begin
    quot = qprod[uemr_pkg::QPROD_W-1:uemr_pkg::RECIP_SHIFT];
    raw  = $signed({1'b0, quot});
    if (tmo) begin
      dist_hcm = '0;
    end else if (quot < uemr_pkg::NEAR_LIMIT) begin
      dist_hcm = raw - uemr_pkg::NEAR_TRIM;
    end else if (quot < uemr_pkg::MID_LIMIT) begin
      dist_hcm = raw - uemr_pkg::MID_TRIM;
    end else begin
      dist_hcm = raw;
    end
  end

  assign push.valid    = (state == F_PUSH);
  assign push.dist_hcm = dist_hcm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      scale <= uemr_pkg::SCALE_RESET;
    end else begin
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            ticks <= echo_ticks;
            tmo   <= timed_out;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod  <= uemr_pkg::PROD_W'(ticks * scale);
          state <= F_DIV;
        end
        F_DIV: begin
          qprod <= uemr_pkg::QPROD_W'(prod[uemr_pkg::PROD_W-1:2] * uemr_pkg::RECIP);
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: src/uemr_queue.sv
module uemr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  uemr_pkg::sample_push_t push,
  output logic                   push_ready,
  output uemr_pkg::sample_push_t pop,
  input  logic                   pop_ready
);

  logic signed [uemr_pkg::DIST_W-1:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready   = (fill != 2'd2);
  assign pop.valid    = (fill != 2'd0);
  assign pop.dist_hcm = mem[rd_ptr];
  assign do_push      = push.valid && push_ready;
  assign do_pop       = pop.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.dist_hcm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: src/uemr_back.sv
module uemr_back #(
  parameter int SAMPLES = uemr_pkg::SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  uemr_pkg::sample_push_t             pop,
  output logic                               pop_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [uemr_pkg::DIST_W-1:0] median_distance
);

  localparam int IDX_W = $clog2(SAMPLES);
  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam logic [CNT_W-1:0] MID  = CNT_W'(SAMPLES / 2);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SAMPLES - 1);

  typedef enum logic [1:0] {B_COLLECT, B_SEARCH, B_EMIT} bstate_t;

  bstate_t                            state;
  logic signed [uemr_pkg::DIST_W-1:0] store [SAMPLES];
  logic [IDX_W-1:0]                   count;
  logic [IDX_W-1:0]                   idx;
  logic signed [uemr_pkg::DIST_W-1:0] med;
  logic signed [uemr_pkg::DIST_W-1:0] cand;
  logic [CNT_W-1:0]                   n_lt;
  logic [CNT_W-1:0]                   n_le;
  logic                               found;

  assign pop_ready = (state == B_COLLECT);

  // Candidate sits at the median rank if at most MID entries are below it
  // and more than MID are at or below it.
  always_comb begin
    cand = store[idx];
    n_lt = '0;
    n_le = '0;
    for (int j = 0; j < SAMPLES; j++) begin
      n_lt = n_lt + {{(CNT_W-1){1'b0}}, (store[j] <  cand)};
      n_le = n_le + {{(CNT_W-1){1'b0}}, (store[j] <= cand)};
    end
    found = (n_lt <= MID) && (n_le > MID);
  end

  always_ff @(posedge clk) begin
    if (state == B_COLLECT && pop.valid) begin
      store[count] <= pop.dist_hcm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_COLLECT;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_COLLECT: begin
          if (pop.valid) begin
            if (count == LAST) begin
              count <= '0;
              idx   <= '0;
              state <= B_SEARCH;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        B_SEARCH: begin
          if (found) begin
            med   <= cand;
            state <= B_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        B_EMIT: begin
          if (!out_valid || out_ready) begin
            median_distance <= med;
            state           <= B_COLLECT;
          end
        end
        default: state <= B_COLLECT;
      endcase
    end
  end

endmodule

FILE: src/ultrasonic_echo_median_ranger.sv
// Channel   Handshake            Payload
// config    cfg_we               cfg_wdata (tick_scale, 10b)
// input     in_valid / in_ready  echo_ticks (16b), timed_out (1b)
// output    out_valid/out_ready  median_distance (21b signed)
//
// Front end takes one transaction at a time (accept, scale multiply,
// reciprocal multiply for /100, push into a 2-entry queue) and takes no new one until the push is taken.
// Median search runs once per set, one candidate
// rank-counted against all stored samples per cycle.
// Synchronous active-high reset; tick_scale returns to 187, sample set empties.
// Front end stalls only on a full queue; the back end stalls on a held output.
module ultrasonic_echo_median_ranger #(
  parameter int SAMPLES = uemr_pkg::SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [uemr_pkg::SCALE_W-1:0]       cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [uemr_pkg::TICKS_W-1:0]       echo_ticks,
  input  logic                               timed_out,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [uemr_pkg::DIST_W-1:0] median_distance
);

  uemr_pkg::sample_push_t push;
  uemr_pkg::sample_push_t pop;
  logic                   push_ready;
  logic                   pop_ready;

  uemr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .echo_ticks (echo_ticks),
    .timed_out  (timed_out),
    .push       (push),
    .push_ready (push_ready)
  );

  uemr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  uemr_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .pop             (pop),
    .pop_ready       (pop_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .median_distance (median_distance)
  );

endmodule

FILE: src/uemr_checker.sv
`include "assert_macros.svh"

module uemr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [uemr_pkg::DIST_W-1:0] median_distance
);

  `ASSERT_CLKD(a_out_hold, out_valid && !out_ready |=> out_valid, "output dropped while stalled")
  `ASSERT_CLKD(a_out_stable, out_valid && !out_ready |=> $stable(median_distance), "output changed while stalled")
  `ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "output valid straight after reset")
  `ASSERT_CLKD(a_floor, out_valid |-> median_distance >= -21'sd40, "median below short-range floor")
  `ASSERT_CLKD(a_busy, in_valid && in_ready |=> !in_ready, "front end took a transaction while busy")

endmodule

bind ultrasonic_echo_median_ranger uemr_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .median_distance (median_distance)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SET_SIZE       = uemr_pkg::SAMPLES_DEF;
  localparam int SCALE_AT_RESET = 187;
  localparam int SCALE_DIV      = 100;
  localparam int NEAR_LIMIT_D   = 1000;
  localparam int MID_LIMIT_D    = 2000;
  localparam int NEAR_OFFSET    = 40;
  localparam int MID_OFFSET     = 80;
  localparam int TICKS_MAX      = 65535;
  localparam int SCALE_MAX      = 1023;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 183;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                               clk        = 1'b0;
  logic                               rst        = 1'b1;
  logic                               cfg_we     = 1'b0;
  logic [uemr_pkg::SCALE_W-1:0]       cfg_wdata  = '0;
  logic                               in_valid   = 1'b0;
  logic                               in_ready;
  logic [uemr_pkg::TICKS_W-1:0]       echo_ticks = '0;
  logic                               timed_out  = 1'b0;
  logic                               out_valid;
  logic                               out_ready  = 1'b0;
  logic signed [uemr_pkg::DIST_W-1:0] median_distance;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  // predictor state
  int                                 scale_model = SCALE_AT_RESET;
  logic signed [uemr_pkg::DIST_W-1:0] dist_set [SET_SIZE];
  int                                 dist_fill = 0;
  logic signed [uemr_pkg::DIST_W-1:0] expected_medians [$];

  int errors          = 0;
  int measurements    = 0;
  int medians_checked = 0;
  int scale_writes    = 0;

  always #5 clk = ~clk;

  ultrasonic_echo_median_ranger i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .echo_ticks      (echo_ticks),
    .timed_out       (timed_out),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .median_distance (median_distance)
  );

  function automatic logic signed [uemr_pkg::DIST_W-1:0] echo_to_distance(
    input logic [uemr_pkg::TICKS_W-1:0] ticks, input logic to);
    int t;
    int d;
    if (to) return '0;
    t = ticks;
    d = t * scale_model / SCALE_DIV;
    if (d < NEAR_LIMIT_D) d -= NEAR_OFFSET;
    else if (d < MID_LIMIT_D) d -= MID_OFFSET;
    return uemr_pkg::DIST_W'(d);
  endfunction

  function automatic logic signed [uemr_pkg::DIST_W-1:0] set_median();
    logic signed [uemr_pkg::DIST_W-1:0] v [SET_SIZE];
    logic signed [uemr_pkg::DIST_W-1:0] tmp;
    v = dist_set;
    for (int i = 0; i < SET_SIZE - 1; i++) begin
      for (int j = i + 1; j < SET_SIZE; j++) begin
        if (v[j] < v[i]) begin
          tmp  = v[i];
          v[i] = v[j];
          v[j] = tmp;
        end
      end
    end
    return v[SET_SIZE / 2];
  endfunction

  function automatic void record_measurement(input logic [uemr_pkg::TICKS_W-1:0] ticks,
                                             input logic to);
    dist_set[dist_fill] = echo_to_distance(ticks, to);
    dist_fill++;
    if (dist_fill == SET_SIZE) begin
      expected_medians.push_back(set_median());
      dist_fill = 0;
    end
  endfunction

  // a mix of full-range ticks, small tick counts and distances up to 2400 spanning the 10 cm and 20 cm trim limits
  function automatic logic [uemr_pkg::TICKS_W-1:0] pick_ticks();
    int pick;
    int t;
    pick = $urandom_range(99);
    if (pick < 45 || scale_model == 0) return uemr_pkg::TICKS_W'($urandom_range(TICKS_MAX));
    if (pick < 60) return uemr_pkg::TICKS_W'($urandom_range(255));
    t = $urandom_range(2400) * SCALE_DIV / scale_model + $urandom_range(1);
    return uemr_pkg::TICKS_W'((t > TICKS_MAX) ? TICKS_MAX : t);
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;  recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 58; recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;  recv_stall_pct = 58;
      end
      default: begin
        send_gap_pct = 21; recv_stall_pct = 21;
      end
    endcase
  endtask

  task automatic send_item(input logic [uemr_pkg::TICKS_W-1:0] ticks, input logic to);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    echo_ticks <= ticks;
    timed_out  <= to;
    do @(posedge clk); while (!in_ready);
    record_measurement(ticks, to);
    measurements++;
  endtask

  task automatic wait_medians();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
  endtask

  // a partial set may still be in the front end with no median pending
  task automatic drain_block();
    wait_medians();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input int s);
    drain_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= uemr_pkg::SCALE_W'(s);
    @(negedge clk);
    cfg_we    <= 1'b0;
    scale_model = s;
    scale_writes++;
  endtask

  task automatic test_reset_scale();
    set_idling(IDLE_NONE);
    send_item(16'd0, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'd0, 1'b1);
    send_item(16'd1, 1'b0);
    send_item(16'd534, 1'b0);
    send_item(16'd535, 1'b0);
    send_item(16'd1069, 1'b0);
    send_item(16'd1070, 1'b0);
  endtask

  // scale 100 makes distance equal the tick count, so the trim limits are hit exactly
  task automatic test_trim_limits();
    write_scale(SCALE_DIV);
    set_idling(IDLE_BOTH);
    send_item(16'd999, 1'b0);
    send_item(16'd1000, 1'b0);
    send_item(16'd1999, 1'b0);
    send_item(16'd2000, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd1001, 1'b0);
    send_item(16'd2001, 1'b0);
    send_item(16'hFFFF, 1'b1);
  endtask

  task automatic test_random_phase(input int s, input idle_mode_e mode, input int n);
    write_scale(s);
    set_idling(mode);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_medians();
      send_item(pick_ticks(), $urandom_range(7) == 0);
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_medians
    logic signed [uemr_pkg::DIST_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_medians.size() == 0) begin
        $error("median_distance: expected none, got %0d", median_distance);
        errors++;
      end else begin
        want = expected_medians.pop_front();
        if (median_distance !== want) begin
          $error("median_distance: expected %0d, got %0d", want, median_distance);
          errors++;
        end
        medians_checked++;
      end
    end
  end

  initial begin
    int s;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_scale();
    test_trim_limits();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       s = SCALE_MAX;
        1:       s = 1;
        2:       s = 0;
        3:       s = SCALE_AT_RESET;
        default: s = $urandom_range(SCALE_MAX, 1);
      endcase
      test_random_phase(s, idle_mode_e'(p % 4), PHASE_ITEMS);
    end
    drain_block();

    $display("%0d echo measurements sent, %0d medians compared over %0d tick_scale writes",
             measurements, medians_checked, scale_writes);
    $display("scales 0, 1, 187, 1023 and random; no idling, sender gaps, receiver stalls, both");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: ultrasonic_echo_median_ranger.f
+incdir+src
src/uemr_pkg.sv
src/uemr_front.sv
src/uemr_queue.sv
src/uemr_back.sv
src/ultrasonic_echo_median_ranger.sv
src/uemr_checker.sv
bench/tb.sv
